>>> sv/pft_pkg.sv
// Shared types, constants and helpers for the transform-to-pose block.
// Depends on nothing; the top, pft_div and pft_cordic use this one by scoped names.
`default_nettype none
package pft_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int ANGLE_FRAC_BITS   = 24;

    localparam int RND_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint RND_HALF_L  = longint'(1) <<< (RND_SHIFT - 1);
    localparam longint PI_A_L      = (PI_Q30 + RND_HALF_L) >>> RND_SHIFT;
    localparam longint TWO_PI_A_L  = (TWO_PI_Q30 + RND_HALF_L) >>> RND_SHIFT;

    localparam logic signed [47:0] PI_A     = 48'(PI_A_L);
    localparam logic signed [47:0] TWO_PI_A = 48'(TWO_PI_A_L);
    localparam logic signed [35:0] HALF_PI  = 36'(HALF_PI_Q30);
    localparam logic signed [35:0] RND_HALF = 36'(RND_HALF_L);

    localparam int CORDIC_CNT_W = $clog2(CORDIC_ITERATIONS);
    localparam int ATAN_IDX_W   = 5;
    localparam int DIV_STEPS    = 32;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIVX,
        S_DIVX_WAIT,
        S_DIVY,
        S_DIVY_WAIT,
        S_CORDIC,
        S_CORDIC_WAIT,
        S_UNW_LO,
        S_UNW_HI,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              flag;
        logic signed [31:0] val;
    } t_sat;

    // Start request of an iterative unit.
    typedef struct packed {
        logic start;
    } t_unit_req;

    function automatic t_sat sat32(input logic signed [47:0] v);
        t_sat s;
        if (v > 48'sd2147483647) begin
            s.flag = 1'b1;
            s.val  = 32'sh7FFF_FFFF;
        end else if (v < -48'sd2147483648) begin
            s.flag = 1'b1;
            s.val  = 32'sh8000_0000;
        end else begin
            s.flag = 1'b0;
            s.val  = v[31:0];
        end
        return s;
    endfunction

    // atan(2^-i) in Q2.30, truncated for i up to 26; the entries for i = 27 to 30 are rounded.
    function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
        logic [31:0] t;
        case (i)
            5'd0:  t = 32'h3243F6A8;
            5'd1:  t = 32'h1DAC6705;
            5'd2:  t = 32'h0FADBAFC;
            5'd3:  t = 32'h07F56EA6;
            5'd4:  t = 32'h03FEAB76;
            5'd5:  t = 32'h01FFD55B;
            5'd6:  t = 32'h00FFFAAA;
            5'd7:  t = 32'h007FFF55;
            5'd8:  t = 32'h003FFFEA;
            5'd9:  t = 32'h001FFFFD;
            5'd10: t = 32'h000FFFFF;
            5'd11: t = 32'h0007FFFF;
            5'd12: t = 32'h0003FFFF;
            5'd13: t = 32'h0001FFFF;
            5'd14: t = 32'h0000FFFF;
            5'd15: t = 32'h00007FFF;
            5'd16: t = 32'h00003FFF;
            5'd17: t = 32'h00001FFF;
            5'd18: t = 32'h00000FFF;
            5'd19: t = 32'h000007FF;
            5'd20: t = 32'h000003FF;
            5'd21: t = 32'h000001FF;
            5'd22: t = 32'h000000FF;
            5'd23: t = 32'h0000007F;
            5'd24: t = 32'h0000003F;
            5'd25: t = 32'h0000001F;
            5'd26: t = 32'h0000000F;
            5'd27: t = 32'h00000008;
            5'd28: t = 32'h00000004;
            5'd29: t = 32'h00000002;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

>>> sv/pose_from_transform_unwrapped.sv
// Top level: sequencer, shared multiplier and result registers.
// Depends on pft_pkg, pft_div and pft_cordic.
//
// Converts the top two rows of a planar homogeneous transform into a pose:
// x and y from the inverse's translation column (Q16.16, truncated toward
// zero, saturated), and the heading atan2(-row1_col0, row0_col0) in Q7.24,
// unwrapped by whole turns to within pi of the previous heading. The
// previous heading resets to zero and is taken as zero for an item with
// start_sequence set. A zero determinant sets singular and forces both
// positions to zero; any clipped output sets saturated. One item is worked
// at a time, and o_ready is high only while the sequencer is idle. After
// acceptance an item passes through the shared 33x33 multiplier for the
// determinant and both numerators, then the serial divider once per
// position (a position whose quotient overflows skips it, and a singular
// item skips it for both), then the CORDIC for the heading, then the
// unwrap, which adds or removes whole turns by compare and add (at most
// 21 turns), and last the output register. o_ready rises in the same
// cycle that the result becomes valid. A finished result sits in the
// output register while the next item is already accepted; a result
// still waiting there holds the sequencer in its last state.
`default_nettype none
module pose_from_transform_unwrapped (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_start_sequence,
    input  wire logic signed [31:0] i_row0_col0,
    input  wire logic signed [31:0] i_row0_col1,
    input  wire logic signed [31:0] i_row0_col2,
    input  wire logic signed [31:0] i_row1_col0,
    input  wire logic signed [31:0] i_row1_col1,
    input  wire logic signed [31:0] i_row1_col2,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_heading,
    output logic                    o_singular,
    output logic                    o_saturated
);
    pft_pkg::t_state r_state, n_state;

    // Held copy of the accepted item.
    logic               r_start;
    logic signed [31:0] r_a, r_b, r_c, r_d, r_e, r_f;

    logic [2:0]         r_step;
    logic signed [65:0] r_acc, r_det, r_numx, r_numy;
    logic signed [31:0] r_px, r_py;
    logic               r_sat;
    logic signed [47:0] r_theta;
    logic signed [31:0] r_prev;

    logic               r_out_valid;
    logic signed [31:0] r_o_px, r_o_py, r_o_hd;
    logic               r_o_sing, r_o_sat;

    logic               accept;
    logic               out_free;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] mul_diff;

    logic signed [65:0] cur_num, abs_num, abs_den;
    logic               div_neg, div_ovf, singular;
    logic [32:0]        div_mag;
    logic signed [47:0] pos_val;
    pft_pkg::t_sat      pos_sat, hd_sat;

    logic signed [47:0] prev_w, bound_lo, bound_hi;
    logic signed [35:0] angle_r;

    pft_pkg::t_unit_req div_req, cor_req;
    logic [79:0]        div_dividend;
    logic [63:0]        div_divisor;
    logic               div_done, cor_done;
    logic [31:0]        div_q;
    logic signed [35:0] cor_angle;

    pft_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    pft_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .i_x     (r_a),
        .i_d     (r_d),
        .o_done  (cor_done),
        .o_angle (cor_angle)
    );

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign singular = (r_det == 66'sd0);

    // Shared multiplier operand select.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == pft_pkg::S_MUL) begin
            case (r_step)
                3'd0: begin mul_a = 33'(r_a); mul_b = 33'(r_e); end
                3'd1: begin mul_a = 33'(r_b); mul_b = 33'(r_d); end
                3'd2: begin mul_a = 33'(r_e); mul_b = 33'(r_c); end
                3'd3: begin mul_a = 33'(r_b); mul_b = 33'(r_f); end
                3'd4: begin mul_a = 33'(r_d); mul_b = 33'(r_c); end
                3'd5: begin mul_a = 33'(r_a); mul_b = 33'(r_f); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        mul_p    = mul_a * mul_b;
        mul_diff = r_acc - mul_p;
    end

    // Position divide setup: sign, magnitudes and overflow of the quotient.
    always_comb begin
        if (r_state == pft_pkg::S_DIVX || r_state == pft_pkg::S_DIVX_WAIT) begin
            cur_num = r_numx;
        end else begin
            cur_num = r_numy;
        end
        abs_num = cur_num[65] ? -cur_num : cur_num;
        abs_den = r_det[65] ? -r_det : r_det;
        div_neg = cur_num[65] != r_det[65];
        div_ovf = {16'b0, abs_num[63:0]} >= {abs_den[63:0], 16'b0};
        div_mag = div_ovf ? 33'h1_0000_0000 : {1'b0, div_q};
        // x carries an extra negation.
        if (r_state == pft_pkg::S_DIVX || r_state == pft_pkg::S_DIVX_WAIT) begin
            pos_val = div_neg ? 48'($signed({1'b0, div_mag}))
                              : -48'($signed({1'b0, div_mag}));
        end else begin
            pos_val = div_neg ? -48'($signed({1'b0, div_mag}))
                              : 48'($signed({1'b0, div_mag}));
        end
        pos_sat = pft_pkg::sat32(pos_val);
    end

    // Heading rounding and unwrap bounds.
    always_comb begin
        angle_r  = (cor_angle + pft_pkg::RND_HALF) >>> pft_pkg::RND_SHIFT;
        prev_w   = r_start ? 48'sd0 : 48'(r_prev);
        bound_lo = prev_w - pft_pkg::PI_A;
        bound_hi = prev_w + pft_pkg::PI_A;
        hd_sat   = pft_pkg::sat32(r_theta);
    end

    always_comb begin
        div_dividend = {abs_num[63:0], 16'b0};
        div_divisor  = abs_den[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pft_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and unit start requests.
    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        cor_req.start = 1'b0;
        o_ready       = 1'b0;
        case (r_state)
            pft_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = pft_pkg::S_MUL;
            end
            pft_pkg::S_MUL: begin
                if (r_step == 3'd5) n_state = pft_pkg::S_DIVX;
            end
            pft_pkg::S_DIVX: begin
                if (singular) begin
                    n_state = pft_pkg::S_CORDIC;
                end else if (div_ovf) begin
                    n_state = pft_pkg::S_DIVY;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = pft_pkg::S_DIVX_WAIT;
                end
            end
            pft_pkg::S_DIVX_WAIT: begin
                if (div_done) n_state = pft_pkg::S_DIVY;
            end
            pft_pkg::S_DIVY: begin
                if (div_ovf) begin
                    n_state = pft_pkg::S_CORDIC;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = pft_pkg::S_DIVY_WAIT;
                end
            end
            pft_pkg::S_DIVY_WAIT: begin
                if (div_done) n_state = pft_pkg::S_CORDIC;
            end
            pft_pkg::S_CORDIC: begin
                cor_req.start = 1'b1;
                n_state       = pft_pkg::S_CORDIC_WAIT;
            end
            pft_pkg::S_CORDIC_WAIT: begin
                if (cor_done) n_state = pft_pkg::S_UNW_LO;
            end
            pft_pkg::S_UNW_LO: begin
                // Stay while a whole turn is still being added.
                if (r_theta >= bound_lo) n_state = pft_pkg::S_UNW_HI;
            end
            pft_pkg::S_UNW_HI: begin
                // Stay while a whole turn is still being removed.
                if (r_theta <= bound_hi) n_state = pft_pkg::S_OUT;
            end
            pft_pkg::S_OUT: begin
                // Hold until the output register is free.
                if (out_free) n_state = pft_pkg::S_IDLE;
            end
            default: n_state = pft_pkg::S_IDLE;
        endcase
    end

    // Control state under reset: output valid and previous heading.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev      <= '0;
        end else begin
            if (r_state == pft_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
                r_prev      <= hd_sat.val;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            pft_pkg::S_IDLE: begin
                if (accept) begin
                    r_start <= i_start_sequence;
                    r_a     <= i_row0_col0;
                    r_b     <= i_row0_col1;
                    r_c     <= i_row0_col2;
                    r_d     <= i_row1_col0;
                    r_e     <= i_row1_col1;
                    r_f     <= i_row1_col2;
                    r_step  <= '0;
                    r_sat   <= 1'b0;
                end
            end
            pft_pkg::S_MUL: begin
                r_step <= r_step + 1'b1;
                if (!r_step[0]) begin
                    r_acc <= mul_p;
                end else begin
                    // Shift in: det first, then x and y numerators.
                    r_det  <= r_numx;
                    r_numx <= r_numy;
                    r_numy <= mul_diff;
                end
            end
            pft_pkg::S_DIVX: begin
                if (singular) begin
                    r_px <= '0;
                    r_py <= '0;
                end else if (div_ovf) begin
                    r_px  <= pos_sat.val;
                    r_sat <= r_sat | pos_sat.flag;
                end
            end
            pft_pkg::S_DIVX_WAIT: begin
                if (div_done) begin
                    r_px  <= pos_sat.val;
                    r_sat <= r_sat | pos_sat.flag;
                end
            end
            pft_pkg::S_DIVY: begin
                if (div_ovf) begin
                    r_py  <= pos_sat.val;
                    r_sat <= r_sat | pos_sat.flag;
                end
            end
            pft_pkg::S_DIVY_WAIT: begin
                if (div_done) begin
                    r_py  <= pos_sat.val;
                    r_sat <= r_sat | pos_sat.flag;
                end
            end
            pft_pkg::S_CORDIC_WAIT: begin
                if (cor_done) r_theta <= 48'(angle_r);
            end
            pft_pkg::S_UNW_LO: begin
                // Advance by one turn per cycle until at or above the low bound.
                if (r_theta < bound_lo) r_theta <= r_theta + pft_pkg::TWO_PI_A;
            end
            pft_pkg::S_UNW_HI: begin
                // Drop one turn per cycle until at or below the high bound.
                if (r_theta > bound_hi) r_theta <= r_theta - pft_pkg::TWO_PI_A;
            end
            pft_pkg::S_OUT: begin
                if (out_free) begin
                    r_o_px   <= r_px;
                    r_o_py   <= r_py;
                    r_o_hd   <= hd_sat.val;
                    r_o_sing <= singular;
                    r_o_sat  <= r_sat | hd_sat.flag;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_o_px;
    assign o_pos_y     = r_o_py;
    assign o_heading   = r_o_hd;
    assign o_singular  = r_o_sing;
    assign o_saturated = r_o_sat;
endmodule
`default_nettype wire

>>> sv/pft_div.sv
// Serial restoring divider, one quotient bit per cycle, 32 bits per run.
// Depends on pft_pkg. Caller guarantees dividend[79:32] < divisor.
`default_nettype none
module pft_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pft_pkg::t_unit_req i_req,
    input  wire logic [79:0]       i_dividend,
    input  wire logic [63:0]       i_divisor,
    output logic                   o_done,
    output logic [31:0]            o_quot
);
    logic                          r_busy;
    logic                          r_done;
    logic [pft_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [63:0]                   r_rem;
    logic [63:0]                   r_den;
    logic [31:0]                   r_q;
    logic [64:0]                   trial;
    logic [64:0]                   diff;
    logic                          take;

    always_comb begin
        trial = {r_rem, r_q[31]};
        diff  = trial - {1'b0, r_den};
        take  = !diff[64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pft_pkg::DIV_CNT_W'(pft_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {16'b0, i_dividend[79:32]};
            r_q   <= i_dividend[31:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[63:0] : trial[63:0];
            r_q   <= {r_q[30:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

>>> sv/pft_cordic.sv
// Vectoring CORDIC, one micro-rotation per cycle, angle out in Q6.30.
// Depends on pft_pkg for the arctangent table and iteration count.
`default_nettype none
module pft_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pft_pkg::t_unit_req i_req,
    input  wire logic signed [31:0] i_x,
    input  wire logic signed [31:0] i_d,
    output logic                    o_done,
    output logic signed [35:0]      o_angle
);
    logic                             r_busy;
    logic                             r_done;
    logic [pft_pkg::CORDIC_CNT_W-1:0] r_i;
    logic signed [63:0]               r_x;
    logic signed [63:0]               r_y;
    logic signed [35:0]               r_z;
    logic                             r_zero;
    logic signed [32:0]               neg_d;
    logic signed [63:0]               x0;
    logic signed [63:0]               y0;
    logic signed [63:0]               dx;
    logic signed [63:0]               dy;
    logic signed [35:0]               at;

    always_comb begin
        neg_d = -$signed({i_d[31], i_d});
        x0    = {{4{i_x[31]}}, i_x, 28'b0};
        y0    = {{3{neg_d[32]}}, neg_d, 28'b0};
        dx    = r_y >>> r_i;
        dy    = r_x >>> r_i;
        at    = $signed({4'b0, pft_pkg::atan_q30(pft_pkg::ATAN_IDX_W'(r_i))});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == pft_pkg::CORDIC_CNT_W'(pft_pkg::CORDIC_ITERATIONS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_zero <= (i_x == 32'sd0) && (i_d == 32'sd0);
            // Pre-rotate the left half plane by a quarter turn.
            if (x0 < 64'sd0) begin
                if (y0 >= 64'sd0) begin
                    r_x <= y0;
                    r_y <= -x0;
                    r_z <= pft_pkg::HALF_PI;
                end else begin
                    r_x <= -y0;
                    r_y <= x0;
                    r_z <= -pft_pkg::HALF_PI;
                end
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 64'sd0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? 36'sd0 : r_z;
endmodule
`default_nettype wire

>>> sv/pft_checker.sv
// Port-level checks for the transform-to-pose block, bound to the top.
// Depends on the top level's ports only.
`default_nettype none
module pft_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_pos_x,
    input wire logic [31:0] o_pos_y,
    input wire logic        o_singular
);
    // One item at a time: the block is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted a second item while busy");

    // A result never appears in the cycle right after an accept.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !$rose(o_valid))
        else $error("result appeared right after accept");

    // Singular results carry zero positions.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_pos_x == 32'd0 && o_pos_y == 32'd0))
        else $error("singular result with nonzero position");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pos_x) && $stable(o_pos_y)))
        else $error("stalled result changed");
endmodule

bind pose_from_transform_unwrapped pft_checker u_pft_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_pos_x    (o_pos_x),
    .o_pos_y    (o_pos_y),
    .o_singular (o_singular)
);
`default_nettype wire
